// ----- hw/rtl/sbca_pkg.sv -----
// Shared types, constants and helpers for the size-class block allocator.
// No dependencies; the other RTL files but sbca_ram refer to it by scoped names.
package sbca_pkg;

  // The payload address space and its split into 32-byte granules.
  localparam int unsigned ADDR_W     = 16;
  localparam int unsigned GRAN_SHIFT = 5;
  localparam int unsigned GRAN_W     = ADDR_W - GRAN_SHIFT;
  localparam int unsigned GRANULES   = 1 << GRAN_W;
  localparam int unsigned ADDR_SPACE = 1 << ADDR_W;

  // The pool top can reach the end of the address space, so it needs one bit more.
  localparam int unsigned TOP_W = ADDR_W + 1;
  localparam int unsigned SUM_W = TOP_W + 1;

  // A class index is three bits wide, whatever the number of classes in use.
  localparam int unsigned CLS_W = 3;

  localparam logic [ADDR_W-1:0] HEADER_BYTES = 16'd8;
  localparam logic [ADDR_W-1:0] MAX_SMALL    = 16'd4088;
  localparam logic [ADDR_W-1:0] MIN_SIZE     = 16'd8;
  localparam int unsigned       MIN_BLOCK    = 32;

  typedef enum logic [1:0] {
    KIND_ALLOC   = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_RESIZE  = 2'd2,
    KIND_NONE    = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NULL      = 2'd1,
    ST_EXHAUSTED = 2'd2,
    ST_TOO_LARGE = 2'd3
  } status_e;

  // A list head or a link: a valid flag and a payload address.
  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] addr;
  } slot_t;

  // Write request to the list head registers.
  typedef struct packed {
    logic             en;
    logic [CLS_W-1:0] cls;
    slot_t            slot;
  } head_wr_t;

  // Granule of the block that a payload address belongs to.
  function automatic logic [GRAN_W-1:0] granule_of(input logic [ADDR_W-1:0] handle);
    logic [ADDR_W-1:0] blk;
    blk = handle - HEADER_BYTES;
    return blk[ADDR_W-1:GRAN_SHIFT];
  endfunction

endpackage

// ----- hw/rtl/sbca_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module sbca_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and read in the same cycle; the read data appears in the next cycle.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/sbca_size_class.sv -----
// Maps a payload size to its power-of-two size class and flags sizes that fit no class.
// Depends on sbca_pkg.
module sbca_size_class #(
  parameter int unsigned NUM_CLASSES = 8
) (
  input  logic [sbca_pkg::ADDR_W-1:0] size_i,
  output logic [sbca_pkg::CLS_W-1:0]  cls_o,
  output logic                        too_large_o
);

  localparam logic [sbca_pkg::CLS_W:0] NUM_CLS = (sbca_pkg::CLS_W + 1)'(NUM_CLASSES);

  logic [12:0] total;
  logic [3:0]  msb;
  logic [sbca_pkg::CLS_W-1:0] cls;

  // Class is the bit length of size plus header rounding, less five.
  always_comb begin
    total = {1'b0, size_i[11:0]} + 13'd7;
    msb   = 4'd0;
    for (int i = 0; i < 13; i++) begin
      if (total[i]) begin
        msb = 4'(i);
      end
    end
    if (size_i <= sbca_pkg::MIN_SIZE) begin
      cls = '0;
    end else begin
      cls = sbca_pkg::CLS_W'(msb - 4'd4);
    end
  end

  assign cls_o       = cls;
  assign too_large_o = (size_i > sbca_pkg::MAX_SMALL) || ({1'b0, cls} >= NUM_CLS);

endmodule

// ----- hw/rtl/sbca_head_file.sv -----
// Free-list head registers, one per size class, with a valid bit each.
// Depends on sbca_pkg.
module sbca_head_file #(
  parameter int unsigned NUM_CLASSES = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  sbca_pkg::head_wr_t         wr_i,
  input  logic [sbca_pkg::CLS_W-1:0] rd_cls_i,
  output sbca_pkg::slot_t            rd_o
);

  sbca_pkg::slot_t heads_q [NUM_CLASSES];

  // Reset empties every list; a write replaces one head.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        heads_q[c] <= '0;
      end
    end else if (wr_i.en) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        if (wr_i.cls == sbca_pkg::CLS_W'(c)) begin
          heads_q[c] <= wr_i.slot;
        end
      end
    end
  end

  // Read the selected head; a class beyond the list count reads as empty.
  always_comb begin
    rd_o = '0;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      if (rd_cls_i == sbca_pkg::CLS_W'(c)) begin
        rd_o = heads_q[c];
      end
    end
  end

endmodule

// ----- hw/rtl/size_class_block_allocator.sv -----
// Top level of the size-class block allocator: request sequencer, link and class memories.
// Depends on sbca_pkg, sbca_ram, sbca_size_class and sbca_head_file.
//
//  Channel   Direction  Fields (lowest bits first)
//  s_axis    in         kind[1:0], request_size[17:2], handle[33:18], zero pad to 40 bits
//  m_axis    out        result_handle[15:0], status[17:16], zero pad to 24 bits
//
// With the receiver ready, a release of a live handle or a resize that keeps its block passes through
// decode, the class read and the response state; an allocate that hits its list passes through
// decode, allocate, pop and response; a resize that moves its block adds the class read and the push.
// Carving a fresh chunk writes its blocks, then returns to allocate, which pops the new list.
// Reset empties every list and sets the pool top to zero; the memories need no clearing.
// One request is in work at a time; the next is taken once the result is loaded, even while it waits.
module size_class_block_allocator #(
  parameter int unsigned NUM_CLASSES = 8,
  parameter int unsigned CHUNK_BYTES = 4096,
  parameter int unsigned POOL_BYTES  = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,  // kind, request_size, handle
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o   // result_handle, status
);

  localparam int unsigned ADDR_W = sbca_pkg::ADDR_W;
  localparam int unsigned GRAN_W = sbca_pkg::GRAN_W;
  localparam int unsigned TOP_W  = sbca_pkg::TOP_W;
  localparam int unsigned SUM_W  = sbca_pkg::SUM_W;
  localparam int unsigned CLS_W  = sbca_pkg::CLS_W;
  localparam int unsigned SLOT_W = ADDR_W + 1;

  localparam int unsigned POOL_CAP =
    (POOL_BYTES > sbca_pkg::ADDR_SPACE) ? sbca_pkg::ADDR_SPACE : POOL_BYTES;
  localparam logic [SUM_W-1:0] POOL_LIMIT = SUM_W'(POOL_CAP);
  localparam logic [SUM_W-1:0] CHUNK      = SUM_W'(CHUNK_BYTES);
  localparam logic [CLS_W:0]   NUM_CLS    = (CLS_W + 1)'(NUM_CLASSES);

  // Sequencer states.
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_ALLOC  = 4'd2;
  localparam logic [3:0] S_CARVE  = 4'd3;
  localparam logic [3:0] S_POP    = 4'd4;
  localparam logic [3:0] S_RSZ_RD = 4'd5;
  localparam logic [3:0] S_REL_RD = 4'd6;
  localparam logic [3:0] S_REL_WR = 4'd7;
  localparam logic [3:0] S_RESP   = 4'd8;

  logic [3:0] state_q, state_d;

  sbca_pkg::kind_e   kind_q, kind_d;
  logic [ADDR_W-1:0] size_q, size_d;
  logic [ADDR_W-1:0] handle_q, handle_d;
  logic              rel_after_q, rel_after_d;
  sbca_pkg::status_e rel_status_q, rel_status_d;
  logic [CLS_W-1:0]  oldcls_q, oldcls_d;
  logic [ADDR_W-1:0] res_handle_q, res_handle_d;
  sbca_pkg::status_e res_status_q, res_status_d;
  logic [TOP_W-1:0]  pool_top_q, pool_top_d;
  logic [TOP_W-1:0]  carve_addr_q, carve_addr_d;
  logic [TOP_W-1:0]  carve_end_q, carve_end_d;
  sbca_pkg::slot_t   carve_prev_q, carve_prev_d;
  logic              out_valid_q, out_valid_d;
  logic [ADDR_W-1:0] out_handle_q, out_handle_d;
  sbca_pkg::status_e out_status_q, out_status_d;

  logic [CLS_W-1:0]  req_cls;
  logic              req_big;
  sbca_pkg::slot_t   head_rd;
  logic [CLS_W-1:0]  head_rd_cls;
  sbca_pkg::head_wr_t head_wr;

  logic              link_we;
  logic [GRAN_W-1:0] link_waddr;
  sbca_pkg::slot_t   link_wdata;
  sbca_pkg::slot_t   link_rdata;
  logic [SLOT_W-1:0] link_rdata_raw;
  logic              cls_we;
  logic [GRAN_W-1:0] cls_waddr;
  logic [CLS_W-1:0]  cls_wdata;
  logic [CLS_W-1:0]  cls_rdata;

  logic [SUM_W-1:0]  bsize;
  logic [SUM_W-1:0]  chunk_end;
  logic [SUM_W-1:0]  carve_next;
  logic [ADDR_W-1:0] carve_payload;
  logic              can_carve;
  logic              start_fits;
  logic              next_fits;
  logic              out_free;

  // Input and output field views.
  sbca_pkg::kind_e   in_kind;
  logic [ADDR_W-1:0] in_size;
  logic [ADDR_W-1:0] in_handle;

  assign in_kind   = sbca_pkg::kind_e'(s_axis_tdata_i[1:0]);
  assign in_size   = s_axis_tdata_i[17:2];
  assign in_handle = s_axis_tdata_i[33:18];

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'd0, out_status_q, out_handle_q};

  // Size class of the request in work.
  sbca_size_class #(
    .NUM_CLASSES(NUM_CLASSES)
  ) u_size_class (
    .size_i     (size_q),
    .cls_o      (req_cls),
    .too_large_o(req_big)
  );

  sbca_head_file #(
    .NUM_CLASSES(NUM_CLASSES)
  ) u_head_file (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (head_wr),
    .rd_cls_i(head_rd_cls),
    .rd_o    (head_rd)
  );

  // Next-link memory, one entry per granule; read at the head being popped.
  sbca_ram #(
    .WIDTH(SLOT_W),
    .DEPTH(sbca_pkg::GRANULES)
  ) u_link_ram (
    .clk_i  (clk_i),
    .we_i   (link_we),
    .waddr_i(link_waddr),
    .wdata_i(link_wdata),
    .raddr_i(sbca_pkg::granule_of(head_rd.addr)),
    .rdata_o(link_rdata_raw)
  );

  assign link_rdata = sbca_pkg::slot_t'(link_rdata_raw);

  // Block class memory, one entry per granule; read at the request's handle.
  sbca_ram #(
    .WIDTH(CLS_W),
    .DEPTH(sbca_pkg::GRANULES)
  ) u_class_ram (
    .clk_i  (clk_i),
    .we_i   (cls_we),
    .waddr_i(cls_waddr),
    .wdata_i(cls_wdata),
    .raddr_i(sbca_pkg::granule_of(handle_q)),
    .rdata_o(cls_rdata)
  );

  // Chunk carving arithmetic.
  assign bsize         = SUM_W'(sbca_pkg::MIN_BLOCK) << req_cls;
  assign chunk_end     = {1'b0, pool_top_q} + CHUNK;
  assign can_carve     = (chunk_end <= POOL_LIMIT);
  assign start_fits    = ({1'b0, pool_top_q} + bsize) <= chunk_end;
  assign carve_next    = {1'b0, carve_addr_q} + bsize;
  assign next_fits     = (carve_next + bsize) <= {1'b0, carve_end_q};
  assign carve_payload = carve_addr_q[ADDR_W-1:0] + sbca_pkg::HEADER_BYTES;
  assign out_free      = !out_valid_q || m_axis_tready_i;

  // Request sequencer.
  always_comb begin
    state_d      = state_q;
    kind_d       = kind_q;
    size_d       = size_q;
    handle_d     = handle_q;
    rel_after_d  = rel_after_q;
    rel_status_d = rel_status_q;
    oldcls_d     = oldcls_q;
    res_handle_d = res_handle_q;
    res_status_d = res_status_q;
    pool_top_d   = pool_top_q;
    carve_addr_d = carve_addr_q;
    carve_end_d  = carve_end_q;
    carve_prev_d = carve_prev_q;
    out_handle_d = out_handle_q;
    out_status_d = out_status_q;
    out_valid_d  = out_valid_q && !m_axis_tready_i;

    head_rd_cls = req_cls;
    head_wr     = '0;
    link_we     = 1'b0;
    link_waddr  = sbca_pkg::granule_of(handle_q);
    link_wdata  = head_rd;
    cls_we      = 1'b0;
    cls_waddr   = carve_addr_q[ADDR_W-1:sbca_pkg::GRAN_SHIFT];
    cls_wdata   = req_cls;

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          kind_d      = in_kind;
          size_d      = in_size;
          handle_d    = in_handle;
          rel_after_d = 1'b0;
          state_d     = S_DECODE;
        end
      end

      S_DECODE: begin
        res_handle_d = '0;
        res_status_d = sbca_pkg::ST_OK;
        unique case (kind_q)
          sbca_pkg::KIND_ALLOC: begin
            state_d = S_ALLOC;
          end
          sbca_pkg::KIND_RELEASE: begin
            rel_status_d = sbca_pkg::ST_OK;
            state_d      = (handle_q == '0) ? S_RESP : S_REL_RD;
          end
          sbca_pkg::KIND_RESIZE: begin
            if (handle_q == '0) begin
              state_d = S_ALLOC;
            end else if (size_q == '0) begin
              rel_status_d = sbca_pkg::ST_NULL;
              state_d      = S_REL_RD;
            end else begin
              state_d = S_RSZ_RD;
            end
          end
          sbca_pkg::KIND_NONE: begin
            state_d = S_RESP;
          end
          default: begin
            state_d = S_RESP;
          end
        endcase
      end

      // Reject null or too-large sizes, pop the class list, or carve a chunk when it is empty.
      S_ALLOC: begin
        res_handle_d = '0;
        priority if (size_q == '0) begin
          res_status_d = sbca_pkg::ST_NULL;
          state_d      = S_RESP;
        end else if (req_big) begin
          res_status_d = sbca_pkg::ST_TOO_LARGE;
          state_d      = S_RESP;
        end else if (head_rd.valid) begin
          state_d = S_POP;
        end else if (!can_carve) begin
          res_status_d = sbca_pkg::ST_EXHAUSTED;
          state_d      = S_RESP;
        end else if (!start_fits) begin
          // The chunk holds no block of this class, yet it is used up.
          pool_top_d   = TOP_W'(chunk_end);
          res_status_d = sbca_pkg::ST_EXHAUSTED;
          state_d      = S_RESP;
        end else begin
          carve_addr_d = pool_top_q;
          carve_end_d  = TOP_W'(chunk_end);
          carve_prev_d = '0;
          state_d      = S_CARVE;
        end
      end

      // Write one block of the chunk per cycle, lowest address first.
      S_CARVE: begin
        link_we      = 1'b1;
        link_waddr   = carve_addr_q[ADDR_W-1:sbca_pkg::GRAN_SHIFT];
        link_wdata   = carve_prev_q;
        cls_we       = 1'b1;
        carve_prev_d = '{valid: 1'b1, addr: carve_payload};
        carve_addr_d = TOP_W'(carve_next);
        if (!next_fits) begin
          head_wr    = '{en: 1'b1, cls: req_cls, slot: '{valid: 1'b1, addr: carve_payload}};
          pool_top_d = carve_end_q;
          state_d    = S_ALLOC;
        end
      end

      S_POP: begin
        head_wr      = '{en: 1'b1, cls: req_cls, slot: link_rdata};
        res_handle_d = head_rd.addr;
        res_status_d = sbca_pkg::ST_OK;
        state_d      = rel_after_q ? S_REL_WR : S_RESP;
      end

      // Resize keeps the block when its class does not change and the new size is not too large.
      S_RSZ_RD: begin
        if (!req_big && (req_cls == cls_rdata)) begin
          res_handle_d = handle_q;
          res_status_d = sbca_pkg::ST_OK;
          state_d      = S_RESP;
        end else begin
          oldcls_d    = cls_rdata;
          rel_after_d = 1'b1;
          state_d     = S_ALLOC;
        end
      end

      // Push the handle onto the list of the class recorded for it.
      S_REL_RD: begin
        head_rd_cls  = cls_rdata;
        link_we      = 1'b1;
        head_wr      = '{en: 1'b1, cls: cls_rdata, slot: '{valid: 1'b1, addr: handle_q}};
        res_handle_d = '0;
        res_status_d = rel_status_q;
        state_d      = S_RESP;
      end

      S_REL_WR: begin
        head_rd_cls = oldcls_q;
        link_we     = 1'b1;
        head_wr     = '{en: 1'b1, cls: oldcls_q, slot: '{valid: 1'b1, addr: handle_q}};
        state_d     = S_RESP;
      end

      S_RESP: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_handle_d = res_handle_q;
          out_status_d = res_status_q;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      kind_q       <= sbca_pkg::KIND_ALLOC;
      size_q       <= '0;
      handle_q     <= '0;
      rel_after_q  <= 1'b0;
      rel_status_q <= sbca_pkg::ST_OK;
      oldcls_q     <= '0;
      res_handle_q <= '0;
      res_status_q <= sbca_pkg::ST_OK;
      pool_top_q   <= '0;
      carve_addr_q <= '0;
      carve_end_q  <= '0;
      carve_prev_q <= '0;
      out_valid_q  <= 1'b0;
      out_handle_q <= '0;
      out_status_q <= sbca_pkg::ST_OK;
    end else begin
      state_q      <= state_d;
      kind_q       <= kind_d;
      size_q       <= size_d;
      handle_q     <= handle_d;
      rel_after_q  <= rel_after_d;
      rel_status_q <= rel_status_d;
      oldcls_q     <= oldcls_d;
      res_handle_q <= res_handle_d;
      res_status_q <= res_status_d;
      pool_top_q   <= pool_top_d;
      carve_addr_q <= carve_addr_d;
      carve_end_q  <= carve_end_d;
      carve_prev_q <= carve_prev_d;
      out_valid_q  <= out_valid_d;
      out_handle_q <= out_handle_d;
      out_status_q <= out_status_d;
    end
  end

  // The pool top never passes the pool limit.
  a_pool_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, pool_top_q} <= POOL_LIMIT)
    else $error("pool top beyond pool limit");

  // A pop only happens from a list that holds a block.
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_POP) |-> head_rd.valid)
    else $error("pop from an empty list");

  // Class entries are written only together with links, and only for a usable class.
  a_class_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cls_we |-> (link_we && ({1'b0, cls_wdata} < NUM_CLS)))
    else $error("bad block class write");

  // A carve ends by moving the pool top up by one chunk.
  a_carve_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CARVE && !next_fits) |=> (pool_top_q == $past(carve_end_q)))
    else $error("carve did not advance pool top");

  // A new result is loaded only when the output register is free.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready_i) |=> $stable(out_handle_q) && $stable(out_status_q))
    else $error("waiting result overwritten");

endmodule
